// ----- src/harmonic_bond_force_core_assert.svh -----
// Assertion macros for the bond force core.
`ifndef HARMONIC_BOND_FORCE_CORE_ASSERT_SVH
`define HARMONIC_BOND_FORCE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define HBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HBF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HBF_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBF_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- src/hbf_pkg.sv -----
`timescale 1ns / 1ps
package hbf_pkg;
    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 26;
    localparam int K_W       = 24;
    localparam int R0_W      = 25;
    localparam int SQ_W      = 54;
    localparam int SEP_W     = 27;
    localparam int DVD_W     = 51;
    localparam int E_W       = 63;
    localparam int F_W       = 40;
    localparam int BOND_W    = 24;
    localparam int MUL_A_W   = 54;
    localparam int MUL_B_W   = 27;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int CNT_W     = 6;
    localparam int CFG_A_W   = 3;

    localparam logic [CNT_W-1:0] MUL_CYCLES  = 6'd27;
    localparam logic [CNT_W-1:0] ROOT_CYCLES = 6'd27;
    localparam logic [CNT_W-1:0] DIV_CYCLES  = 6'd51;

    localparam logic [CFG_A_W-1:0] REG_SPRING_K   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_REST_LEN   = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_BOX_X      = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_BOX_Y      = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_BOX_Z      = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_PERIODIC   = 3'd5;

    localparam logic [K_W-1:0]   RST_K      = 24'd65536;
    localparam logic [R0_W-1:0]  RST_R0     = 25'd65536;
    localparam logic [POS_W-1:0] RST_BOX    = 26'h3FFFFFF;
    localparam logic [SQ_W-1:0]  RST_MIN_SQ = 54'd1 << 34;
    localparam logic [SEP_W-1:0] RST_MIN_SEP = 27'd1 << 17;
    localparam logic [E_W-1:0]   E_MAX      = {E_W{1'b1}};
    localparam logic [BOND_W-1:0] CNT_MAX   = {BOND_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_DSQ,
        ST_KDIV,
        ST_FORCE,
        ST_DONE
    } t_state;
endpackage

// ----- src/harmonic_bond_force_core.sv -----
`timescale 1ns / 1ps
// channel | handshake                 | payload
// config  | i_cfg_we                  | i_cfg_addr, i_cfg_wdata
// bond in | i_in_valid / o_in_ready   | i_first_of_frame, i_first_pos_*, i_second_pos_*
// result  | o_out_valid / i_out_ready | o_force_*, o_energy_sum, o_bond_total, o_*_separation,
//         |                           | o_bond_broken
// One bond at a time: the next bond is accepted only after the previous one commits.
// The pace is set by the bit-serial units: three 27-step multiply passes, a 27-step
// square root and a 51-step divide for k*|r0-r|/r (the energy product runs beside
// the divide), each loaded before it steps, followed by the commit.
// A finished result sits in the output register; the next bond is accepted meanwhile
// and only its final commit waits on i_out_ready. Synchronous active-low reset.
module harmonic_bond_force_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbf_pkg::CFG_A_W-1:0]         i_cfg_addr,
    input  logic [hbf_pkg::POS_W-1:0]           i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_first_of_frame,
    input  logic [hbf_pkg::POS_W-1:0]           i_first_pos_x,
    input  logic [hbf_pkg::POS_W-1:0]           i_first_pos_y,
    input  logic [hbf_pkg::POS_W-1:0]           i_first_pos_z,
    input  logic [hbf_pkg::POS_W-1:0]           i_second_pos_x,
    input  logic [hbf_pkg::POS_W-1:0]           i_second_pos_y,
    input  logic [hbf_pkg::POS_W-1:0]           i_second_pos_z,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hbf_pkg::F_W-1:0]      o_force_x,
    output logic signed [hbf_pkg::F_W-1:0]      o_force_y,
    output logic signed [hbf_pkg::F_W-1:0]      o_force_z,
    output logic [hbf_pkg::E_W-1:0]             o_energy_sum,
    output logic [hbf_pkg::BOND_W-1:0]          o_bond_total,
    output logic [hbf_pkg::POS_W-1:0]           o_min_separation,
    output logic [hbf_pkg::POS_W-1:0]           o_max_separation,
    output logic                                o_bond_broken
);
    import hbf_pkg::*;
`include "harmonic_bond_force_core_assert.svh"

    // single minimum-image correction, as signed separation
    function automatic logic signed [POS_W+1:0] f_min_image(
        input logic [POS_W-1:0] f, input logic [POS_W-1:0] s,
        input logic [POS_W-1:0] box, input logic per);
        logic signed [POS_W+1:0] d;
        logic signed [POS_W+2:0] d2;
        logic signed [POS_W+2:0] len;
        d   = $signed({2'b00, s}) - $signed({2'b00, f});
        d2  = {d, 1'b0};
        len = $signed({3'b000, box});
        if (per) begin
            if (d2 > len) d = d - $signed({2'b00, box});
            else if (d2 < -len) d = d + $signed({2'b00, box});
        end
        return d;
    endfunction

    function automatic logic [POS_W-1:0] f_mag(input logic signed [POS_W+1:0] d);
        logic [POS_W+1:0] m;
        m = d[POS_W+1] ? 28'(-d) : 28'(d);
        return m[POS_W-1:0];
    endfunction

    // |F| = (g*|d|) >> FRAC_BITS, saturated at 40 bits, then signed
    function automatic logic [F_W-1:0] f_force(input logic [MUL_P_W-1:0] p,
                                               input logic neg, input logic zero);
        logic [MUL_P_W-1:0] sh;
        logic [F_W-1:0]     m;
        sh = p >> FRAC_BITS;
        if (sh > MUL_P_W'({1'b0, {(F_W-1){1'b1}}}))
            m = neg ? {1'b1, {(F_W-1){1'b0}}} : {1'b0, {(F_W-1){1'b1}}};
        else
            m = sh[F_W-1:0];
        if (zero) return '0;
        return neg ? (~m + 1'b1) : m;
    endfunction

    // config
    logic [K_W-1:0]   r_k;
    logic [R0_W-1:0]  r_r0;
    logic [POS_W-1:0] r_box_x, r_box_y, r_box_z;
    logic [2:0]       r_per;

    // control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              in_acc, commit;

    // item
    logic              r_frame;
    logic [POS_W-1:0]  r_mag [0:2];
    logic [2:0]        r_neg_d;
    logic              r_neg_diff;
    logic [SQ_W-1:0]   r_r2, r_lim;
    logic [E_W-1:0]    r_eterm;

    // serial units
    logic [3:0]          mul_load, mul_step;
    logic [MUL_A_W-1:0]  mul_a [0:3];
    logic [MUL_B_W-1:0]  mul_b [0:3];
    logic [MUL_P_W-1:0]  mul_p [0:3];
    logic                root_load, root_step, div_load, div_step;
    logic [SQ_W-1:0]     r_rad;
    logic [27:0]         r_rem;
    logic [SEP_W-1:0]    r_root;
    logic [29:0]         rem_sh, trial, rem_diff;
    logic [DVD_W-1:0]    r_dvd;
    logic [SEP_W-1:0]    r_drem;
    logic [SEP_W:0]      drem_sh, drem_diff;

    // stats
    logic [E_W-1:0]    r_energy;
    logic [BOND_W-1:0] r_count;
    logic [SQ_W-1:0]   r_min_sq, r_max_sq;
    logic [SEP_W-1:0]  r_min_sep, r_max_sep;

    // output register
    logic              r_ov;
    logic [F_W-1:0]    r_fx, r_fy, r_fz;
    logic [E_W-1:0]    r_o_energy;
    logic [BOND_W-1:0] r_o_count;
    logic [POS_W-1:0]  r_o_min, r_o_max;
    logic              r_o_broken;

    logic signed [POS_W+1:0] d_x, d_y, d_z;
    logic signed [SEP_W:0]   diff;
    logic [SEP_W-1:0]        dmag;
    logic [SQ_W-1:0]         r2_sum;

    assign d_x = f_min_image(i_first_pos_x, i_second_pos_x, r_box_x, r_per[0]);
    assign d_y = f_min_image(i_first_pos_y, i_second_pos_y, r_box_y, r_per[1]);
    assign d_z = f_min_image(i_first_pos_z, i_second_pos_z, r_box_z, r_per[2]);

    assign diff = $signed({3'b000, r_r0}) - $signed({1'b0, r_root});
    assign dmag = diff[SEP_W] ? SEP_W'(-diff) : diff[SEP_W-1:0];
    assign r2_sum = mul_p[0][SQ_W-1:0] + mul_p[1][SQ_W-1:0] + mul_p[2][SQ_W-1:0];

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= RST_K;
            r_r0    <= RST_R0;
            r_box_x <= RST_BOX;
            r_box_y <= RST_BOX;
            r_box_z <= RST_BOX;
            r_per   <= 3'b111;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SPRING_K: r_k     <= i_cfg_wdata[K_W-1:0];
                REG_REST_LEN: r_r0    <= i_cfg_wdata[R0_W-1:0];
                REG_BOX_X:    r_box_x <= i_cfg_wdata;
                REG_BOX_Y:    r_box_y <= i_cfg_wdata;
                REG_BOX_Z:    r_box_z <= i_cfg_wdata;
                REG_PERIODIC: r_per   <= i_cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // each phase: count 0 loads the units, counts 1..N step them
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        mul_load  = '0;
        mul_step  = '0;
        root_load = 1'b0;
        root_step = 1'b0;
        div_load  = 1'b0;
        div_step  = 1'b0;
        commit    = 1'b0;
        for (int i = 0; i < 4; i++) begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SQ;
                    n_cnt   = '0;
                end
            end
            ST_SQ: begin
                // squares of the three separations, and r0^2 for the broken limit
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = MUL_A_W'(r_mag[i]);
                    mul_b[i] = MUL_B_W'(r_mag[i]);
                end
                mul_a[3] = MUL_A_W'(r_r0);
                mul_b[3] = MUL_B_W'(r_r0);
                if (r_cnt == '0) mul_load = 4'hF;
                else mul_step = 4'hF;
                if (r_cnt == MUL_CYCLES) begin
                    n_state = ST_ROOT;
                    n_cnt   = '0;
                end else n_cnt = r_cnt + 1'b1;
            end
            ST_ROOT: begin
                if (r_cnt == '0) root_load = 1'b1;
                else root_step = 1'b1;
                if (r_cnt == ROOT_CYCLES) begin
                    n_state = ST_DSQ;
                    n_cnt   = '0;
                end else n_cnt = r_cnt + 1'b1;
            end
            ST_DSQ: begin
                // lane 0: |r0-r|^2, lane 3: k*|r0-r|
                mul_a[0] = MUL_A_W'(dmag);
                mul_b[0] = dmag;
                mul_a[3] = MUL_A_W'(dmag);
                mul_b[3] = MUL_B_W'(r_k);
                if (r_cnt == '0) mul_load = 4'b1001;
                else mul_step = 4'b1001;
                if (r_cnt == MUL_CYCLES) begin
                    n_state = ST_KDIV;
                    n_cnt   = '0;
                end else n_cnt = r_cnt + 1'b1;
            end
            ST_KDIV: begin
                // energy product runs beside the divide
                mul_a[0] = mul_p[0][MUL_A_W-1:0];
                mul_b[0] = MUL_B_W'(r_k);
                if (r_cnt == '0) begin
                    mul_load[0] = 1'b1;
                    div_load    = 1'b1;
                end else begin
                    div_step    = 1'b1;
                    mul_step[0] = (r_cnt <= MUL_CYCLES);
                end
                if (r_cnt == DIV_CYCLES) begin
                    n_state = ST_FORCE;
                    n_cnt   = '0;
                end else n_cnt = r_cnt + 1'b1;
            end
            ST_FORCE: begin
                for (int i = 0; i < 3; i++) begin
                    mul_a[i] = MUL_A_W'(r_dvd);
                    mul_b[i] = MUL_B_W'(r_mag[i]);
                end
                if (r_cnt == '0) mul_load = 4'b0111;
                else mul_step = 4'b0111;
                if (r_cnt == MUL_CYCLES) begin
                    n_state = ST_DONE;
                    n_cnt   = '0;
                end else n_cnt = r_cnt + 1'b1;
            end
            ST_DONE: begin
                if (!r_ov || i_out_ready) begin
                    commit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    hbf_smul u_mul0 (.i_clk(i_clk), .i_load(mul_load[0]), .i_step(mul_step[0]),
                     .i_a(mul_a[0]), .i_b(mul_b[0]), .o_prod(mul_p[0]));
    hbf_smul u_mul1 (.i_clk(i_clk), .i_load(mul_load[1]), .i_step(mul_step[1]),
                     .i_a(mul_a[1]), .i_b(mul_b[1]), .o_prod(mul_p[1]));
    hbf_smul u_mul2 (.i_clk(i_clk), .i_load(mul_load[2]), .i_step(mul_step[2]),
                     .i_a(mul_a[2]), .i_b(mul_b[2]), .o_prod(mul_p[2]));
    hbf_smul u_mul3 (.i_clk(i_clk), .i_load(mul_load[3]), .i_step(mul_step[3]),
                     .i_a(mul_a[3]), .i_b(mul_b[3]), .o_prod(mul_p[3]));

    // square root: two radicand bits in, one root bit out per step
    assign rem_sh   = {r_rem, r_rad[SQ_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge i_clk) begin
        if (root_load) begin
            r_rad  <= r2_sum;
            r_rem  <= '0;
            r_root <= '0;
        end else if (root_step) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_diff[27:0];
                r_root <= {r_root[SEP_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[27:0];
                r_root <= {r_root[SEP_W-2:0], 1'b0};
            end
        end
    end

    // restoring divide k*|r0-r| / r, quotient shifts into the dividend register
    assign drem_sh   = {r_drem, r_dvd[DVD_W-1]};
    assign drem_diff = drem_sh - {1'b0, r_root};

    always_ff @(posedge i_clk) begin
        if (div_load) begin
            r_dvd  <= mul_p[3][DVD_W-1:0];
            r_drem <= '0;
        end else if (div_step) begin
            if (drem_sh >= {1'b0, r_root}) begin
                r_drem <= drem_diff[SEP_W-1:0];
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_drem <= drem_sh[SEP_W-1:0];
                r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    // per-item captures
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_frame  <= i_first_of_frame;
            r_mag[0] <= f_mag(d_x);
            r_mag[1] <= f_mag(d_y);
            r_mag[2] <= f_mag(d_z);
            r_neg_d  <= {d_z[POS_W+1], d_y[POS_W+1], d_x[POS_W+1]};
        end
        if (root_load) begin
            r_r2  <= r2_sum;
            r_lim <= {mul_p[3][SQ_W-3:0], 2'b00};
        end
        if (r_state == ST_DSQ && r_cnt == '0) r_neg_diff <= diff[SEP_W];
        if (r_state == ST_FORCE && r_cnt == '0)
            r_eterm <= mul_p[0][FRAC_BITS+1 +: E_W];
    end

    // commit: frame restart first, then this bond's contribution
    logic [E_W-1:0]    e_base, e_new;
    logic [BOND_W-1:0] c_base, c_new;
    logic [SQ_W-1:0]   mn_sq_base, mx_sq_base, mn_sq_new, mx_sq_new;
    logic [SEP_W-1:0]  mn_sep_base, mx_sep_base, mn_sep_new, mx_sep_new;
    logic              zero_len;

    assign e_base      = r_frame ? '0 : r_energy;
    assign e_new       = (r_eterm > E_MAX - e_base) ? E_MAX : e_base + r_eterm;
    assign c_base      = r_frame ? '0 : r_count;
    assign c_new       = (c_base < CNT_MAX) ? c_base + 1'b1 : c_base;
    assign mn_sq_base  = r_frame ? r_lim : r_min_sq;
    assign mn_sep_base = r_frame ? {1'b0, r_r0, 1'b0} : r_min_sep;
    assign mx_sq_base  = r_frame ? '0 : r_max_sq;
    assign mx_sep_base = r_frame ? '0 : r_max_sep;
    // floor sqrt is monotonic, so the stored root follows the stored square
    assign mn_sq_new   = (r_r2 < mn_sq_base) ? r_r2 : mn_sq_base;
    assign mn_sep_new  = (r_r2 < mn_sq_base) ? r_root : mn_sep_base;
    assign mx_sq_new   = (r_r2 > mx_sq_base) ? r_r2 : mx_sq_base;
    assign mx_sep_new  = (r_r2 > mx_sq_base) ? r_root : mx_sep_base;
    assign zero_len    = (r_root == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy  <= '0;
            r_count   <= '0;
            r_min_sq  <= RST_MIN_SQ;
            r_min_sep <= RST_MIN_SEP;
            r_max_sq  <= '0;
            r_max_sep <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (commit) begin
                r_energy  <= e_new;
                r_count   <= c_new;
                r_min_sq  <= mn_sq_new;
                r_min_sep <= mn_sep_new;
                r_max_sq  <= mx_sq_new;
                r_max_sep <= mx_sep_new;
                r_ov      <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_fx       <= f_force(mul_p[0], r_neg_diff ^ r_neg_d[0], zero_len);
            r_fy       <= f_force(mul_p[1], r_neg_diff ^ r_neg_d[1], zero_len);
            r_fz       <= f_force(mul_p[2], r_neg_diff ^ r_neg_d[2], zero_len);
            r_o_energy <= e_new;
            r_o_count  <= c_new;
            r_o_min    <= mn_sep_new[SEP_W-1] ? {POS_W{1'b1}} : mn_sep_new[POS_W-1:0];
            r_o_max    <= mx_sep_new[SEP_W-1] ? {POS_W{1'b1}} : mx_sep_new[POS_W-1:0];
            r_o_broken <= (r_r2 > r_lim);
        end
    end

    assign o_out_valid      = r_ov;
    assign o_force_x        = $signed(r_fx);
    assign o_force_y        = $signed(r_fy);
    assign o_force_z        = $signed(r_fz);
    assign o_energy_sum     = r_o_energy;
    assign o_bond_total     = r_o_count;
    assign o_min_separation = r_o_min;
    assign o_max_separation = r_o_max;
    assign o_bond_broken    = r_o_broken;

    `HBF_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, in_acc, r_state == ST_SQ && r_cnt == '0, "accepted item did not start the square pass")
    `HBF_ASSERT(a_root_count, i_clk, i_rst_n, r_state == ST_ROOT |-> r_cnt <= ROOT_CYCLES, "root step count overran")
    `HBF_ASSERT_NEXT(a_count_mono, i_clk, i_rst_n, commit && !r_frame, r_count >= $past(r_count), "bond count went down within a frame")
    `HBF_ASSERT_NEXT(a_commit_valid, i_clk, i_rst_n, commit, o_out_valid, "committed item not presented")
endmodule

// ----- src/hbf_smul.sv -----
`timescale 1ns / 1ps
// Shift-add multiplier, one bit of b per step, product valid after MUL_B_W steps.
module hbf_smul (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [hbf_pkg::MUL_A_W-1:0]  i_a,
    input  logic [hbf_pkg::MUL_B_W-1:0]  i_b,
    output logic [hbf_pkg::MUL_P_W-1:0]  o_prod
);
    import hbf_pkg::*;

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_P_W-1:0] r_acc;
    logic [MUL_A_W:0]   sum;

    assign sum = {1'b0, r_acc[MUL_P_W-1:MUL_B_W]} + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (i_step) begin
            r_b   <= {1'b0, r_b[MUL_B_W-1:1]};
            r_acc <= {sum, r_acc[MUL_B_W-1:1]};
        end
    end

    assign o_prod = r_acc;
endmodule
